>>> hw/rtl/frame_pacing_deadline_keeper_macros.svh
// ---------------------------------------------------------------------------
// Frame pacing deadline keeper: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge of clock.
// ---------------------------------------------------------------------------
`ifndef FRAME_PACING_DEADLINE_KEEPER_MACROS_SVH
`define FRAME_PACING_DEADLINE_KEEPER_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define FPDK_ASSERT_NEXT(lbl, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// consequent checked in the same cycle
`define FPDK_ASSERT_SAME(lbl, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/fpdk_pkg.sv
// ---------------------------------------------------------------------------
// Frame pacing deadline keeper: package
// Field widths, register defaults, codes and the sequencer state type.
// ---------------------------------------------------------------------------
package fpdk_pkg;

   localparam int TIME_W  = 48;
   localparam int CAD_W   = 20;
   localparam int STALE_W = 8;
   localparam int CNT_W   = 32;
   localparam int PROD_W  = CAD_W + STALE_W;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [CAD_W-1:0]   CAD_LOW     = 20'd1000;
   localparam logic [CAD_W-1:0]   CAD_HIGH    = 20'd1000000;
   localparam logic [CAD_W-1:0]   CAD_RESET   = 20'd16667;
   localparam logic [STALE_W-1:0] STALE_RESET = 8'd4;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_REQ  = 1'b1;

   localparam logic [1:0] REG_CADENCE = 2'd0;
   localparam logic [1:0] REG_STALE   = 2'd1;
   localparam logic [1:0] REG_PAUSED  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_FRESH,
      S_BOUND,
      S_ANCHOR,
      S_CHECK,
      S_DIV,
      S_STEP,
      S_STORE,
      S_DONE
   } fpdk_state_type;

endpackage

>>> hw/rtl/frame_pacing_deadline_keeper.sv
// ---------------------------------------------------------------------------
// Frame pacing deadline keeper
// Counts vertical-blank ticks and paces engine requests against per-engine
// deadlines that follow the frame cadence.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | op, time_us, engine
//   rsp     | out       | rsp_valid/stall    | must_wait, deadline_usec, tick_total
//   csr     | in        | psel/penable/pready| paddr, pwdata, prdata
//
// One transaction at a time. A tick goes straight to the result; a request
// skips the division when the deadline already lies past now, else the serial
// remainder unit walks the 48-bit time gap one bit per cycle.
// Reset is synchronous; it clears the tick history, counter and deadlines.
// The result register lets a new transaction in while its result waits.
// ---------------------------------------------------------------------------
module frame_pacing_deadline_keeper
   import fpdk_pkg::*;
#(
   parameter int ENGINE_COUNT = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [TIME_W-1:0]  req_time_us,
   input  logic [3:0]         req_engine,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_must_wait,
   output logic [TIME_W-1:0]  rsp_deadline_usec,
   output logic [CNT_W-1:0]   rsp_tick_total,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   localparam int ENG_W = (ENGINE_COUNT > 1) ? $clog2(ENGINE_COUNT) : 1;

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? '1 : s[TIME_W-1:0];
   endfunction

   fpdk_state_type state_ff, state_in;

   logic [CAD_W-1:0]   cad_ff, cad_in;
   logic [STALE_W-1:0] stale_ff, stale_in;
   logic               paused_ff, paused_in;

   logic [TIME_W-1:0]  last_ff, last_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TIME_W-1:0]  dl_mem_ff [ENGINE_COUNT];
   logic [TIME_W-1:0]  dl_mem_in [ENGINE_COUNT];

   logic [TIME_W-1:0]  now_ff, now_in;
   logic [ENG_W-1:0]   eng_ff, eng_in;
   logic [TIME_W-1:0]  dl_ff, dl_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               fresh_ff, fresh_in;
   logic [TIME_W-1:0]  fb_ff, fb_in;
   logic [TIME_W-1:0]  anchor_ff, anchor_in;
   logic [TIME_W-1:0]  bound_ff, bound_in;
   logic               wait_ff, wait_in;

   logic               res_wait_ff, res_wait_in;
   logic [TIME_W-1:0]  res_dl_ff, res_dl_in;
   logic [CNT_W-1:0]   res_tick_ff, res_tick_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_wait_ff, rsp_wait_in;
   logic [TIME_W-1:0]  rsp_dl_ff, rsp_dl_in;
   logic [CNT_W-1:0]   rsp_tick_ff, rsp_tick_in;

   logic [CAD_W-1:0]   cad_eff;
   logic [STALE_W-1:0] stale_eff;
   logic [TIME_W-1:0]  cad_t;
   logic               cfg_wr;
   logic               out_free;
   logic               out_load;
   logic               req_take;
   logic               dl_past;
   logic               mod_start;
   logic               mod_done;
   logic [CAD_W-1:0]   mod_rem;

   assign cad_eff   = (cad_ff < CAD_LOW) ? CAD_LOW : ((cad_ff > CAD_HIGH) ? CAD_HIGH : cad_ff);
   assign stale_eff = (stale_ff == '0) ? STALE_W'(1) : stale_ff;
   assign cad_t     = TIME_W'(cad_eff);
   assign dl_past   = dl_ff > now_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cfg_wr    = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   // configuration registers
   always_comb begin
      cad_in    = cad_ff;
      stale_in  = stale_ff;
      paused_in = paused_ff;
      if (cfg_wr) begin
         unique case (paddr[ADDR_W-1:2])
            REG_CADENCE: cad_in    = pwdata[CAD_W-1:0];
            REG_STALE:   stale_in  = pwdata[STALE_W-1:0];
            REG_PAUSED:  paused_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[ADDR_W-1:2])
         REG_CADENCE: prdata = DATA_W'(cad_ff);
         REG_STALE:   prdata = DATA_W'(stale_ff);
         REG_PAUSED:  prdata = DATA_W'(paused_ff);
         default:     prdata = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) begin
                      state_in = (req_op == OP_TICK) ? S_DONE : S_LOAD;
                   end
         S_LOAD:   state_in = S_FRESH;
         S_FRESH:  state_in = S_BOUND;
         S_BOUND:  state_in = S_ANCHOR;
         S_ANCHOR: state_in = S_CHECK;
         S_CHECK:  state_in = dl_past ? S_STORE : S_DIV;
         S_DIV:    if (mod_done) begin
                      state_in = S_STEP;
                   end
         S_STEP:   state_in = S_STORE;
         S_STORE:  state_in = S_DONE;
         S_DONE:   if (out_free) begin
                      state_in = S_IDLE;
                   end
         default:  state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = (state_ff != S_IDLE);
      req_take  = (state_ff == S_IDLE) && req_valid;
      mod_start = (state_ff == S_CHECK) && !dl_past;
      out_load  = (state_ff == S_DONE) && out_free;
   end

   // datapath
   always_comb begin
      last_in     = last_ff;
      count_in    = count_ff;
      dl_mem_in   = dl_mem_ff;
      now_in      = now_ff;
      eng_in      = eng_ff;
      dl_in       = dl_ff;
      prod_in     = prod_ff;
      fresh_in    = fresh_ff;
      fb_in       = fb_ff;
      anchor_in   = anchor_ff;
      bound_in    = bound_ff;
      wait_in     = wait_ff;
      res_wait_in = res_wait_ff;
      res_dl_in   = res_dl_ff;
      res_tick_in = res_tick_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               now_in = req_time_us;
               eng_in = ({28'd0, req_engine} < ENGINE_COUNT) ? ENG_W'(req_engine) : '0;
               if (req_op == OP_TICK) begin
                  res_wait_in = 1'b0;
                  res_dl_in   = '0;
                  if (paused_ff) begin
                     res_tick_in = count_ff;
                  end else begin
                     count_in    = count_ff + 1'b1;
                     last_in     = req_time_us;
                     res_tick_in = count_ff + 1'b1;
                  end
               end
            end
         end
         S_LOAD: begin
            dl_in   = dl_mem_ff[eng_ff];
            prod_in = {{STALE_W{1'b0}}, cad_eff} * {{CAD_W{1'b0}}, stale_eff};
         end
         S_FRESH: begin
            fresh_in  = (last_ff != '0) && (now_ff <= sat_add(last_ff, TIME_W'(prod_ff)));
            fb_in     = sat_add(now_ff, cad_t);
            anchor_in = sat_add(last_ff, cad_t);
         end
         S_BOUND: begin
            bound_in = fresh_ff ? sat_add(last_ff, {cad_t[TIME_W-2:0], 1'b0})
                                : sat_add(fb_ff, cad_t);
         end
         S_ANCHOR: begin
            if (!fresh_ff) begin
               if (dl_ff == '0 || dl_ff <= now_ff || dl_ff > bound_ff) begin
                  dl_in = fb_ff;
               end
            end else if (dl_ff == '0 || dl_ff > bound_ff) begin
               dl_in = anchor_ff;
            end
         end
         S_CHECK: begin
            wait_in = !(fresh_ff && dl_ff <= now_ff);
         end
         S_DIV: ;
         S_STEP: begin
            // now - rem + cadence is the first cadence step past now
            dl_in = sat_add(now_ff, TIME_W'(cad_eff - mod_rem));
         end
         S_STORE: begin
            dl_mem_in[eng_ff] = wait_ff ? sat_add(dl_ff, cad_t) : dl_ff;
            res_wait_in = wait_ff;
            res_dl_in   = dl_ff;
            res_tick_in = count_ff;
         end
         S_DONE: ;
         default: ;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_dl_in    = rsp_dl_ff;
      rsp_tick_in  = rsp_tick_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_wait_in  = res_wait_ff;
         rsp_dl_in    = res_dl_ff;
         rsp_tick_in  = res_tick_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cad_ff       <= CAD_RESET;
         stale_ff     <= STALE_RESET;
         paused_ff    <= 1'b0;
         last_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENGINE_COUNT; i++) begin
            dl_mem_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cad_ff       <= cad_in;
         stale_ff     <= stale_in;
         paused_ff    <= paused_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         dl_mem_ff    <= dl_mem_in;
      end
      now_ff      <= now_in;
      eng_ff      <= eng_in;
      dl_ff       <= dl_in;
      prod_ff     <= prod_in;
      fresh_ff    <= fresh_in;
      fb_ff       <= fb_in;
      anchor_ff   <= anchor_in;
      bound_ff    <= bound_in;
      wait_ff     <= wait_in;
      res_wait_ff <= res_wait_in;
      res_dl_ff   <= res_dl_in;
      res_tick_ff <= res_tick_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_dl_ff   <= rsp_dl_in;
      rsp_tick_ff <= rsp_tick_in;
   end

   fpdk_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (now_ff - dl_ff),
      .divisor   (cad_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_must_wait     = rsp_wait_ff;
   assign rsp_deadline_usec = rsp_dl_ff;
   assign rsp_tick_total    = rsp_tick_ff;

endmodule

>>> hw/rtl/fpdk_mod.sv
// ---------------------------------------------------------------------------
// Frame pacing deadline keeper: serial remainder unit
// Restoring division, one dividend bit per cycle; yields the remainder only.
// ---------------------------------------------------------------------------
module fpdk_mod
   import fpdk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] dividend,
   input  logic [CAD_W-1:0]  divisor,
   output logic              done,
   output logic [CAD_W-1:0]  remainder
);

   localparam int BIT_W = $clog2(TIME_W);

   logic [TIME_W-1:0] shift_ff, shift_in;
   logic [CAD_W-1:0]  rem_ff, rem_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CAD_W:0]    trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, shift_ff[TIME_W-1]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         bit_in   = BIT_W'(TIME_W - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[TIME_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = CAD_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[CAD_W-1:0];
         end
         bit_in = bit_ff - 1'b1;
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> hw/rtl/fpdk_check.sv
// ---------------------------------------------------------------------------
// Frame pacing deadline keeper: port checker
// Watches the transaction ports of the top level over time.
// ---------------------------------------------------------------------------
`include "frame_pacing_deadline_keeper_macros.svh"

module fpdk_check
   import fpdk_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_must_wait,
   input logic [TIME_W-1:0] rsp_deadline_usec,
   input logic [CNT_W-1:0]  rsp_tick_total
);

   `FPDK_ASSERT_NEXT(a_rsp_hold, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   `FPDK_ASSERT_NEXT(a_rsp_stable, reset, rsp_valid && rsp_stall, $stable(rsp_must_wait) && $stable(rsp_deadline_usec) && $stable(rsp_tick_total), "stalled result changed")
   `FPDK_ASSERT_NEXT(a_one_at_a_time, reset, req_valid && !req_stall, req_stall, "second transaction taken while busy")
   `FPDK_ASSERT_NEXT(a_reset_empty, 1'b0, reset, !rsp_valid, "result valid after reset")
   `FPDK_ASSERT_SAME(a_wait_deadline, reset, rsp_valid && rsp_must_wait, rsp_deadline_usec != '0, "wait with no deadline")

endmodule

bind frame_pacing_deadline_keeper fpdk_check u_fpdk_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_must_wait     (rsp_must_wait),
   .rsp_deadline_usec (rsp_deadline_usec),
   .rsp_tick_total    (rsp_tick_total)
);
